// ===== rtl/core/psrld_pkg.sv =====
// shared types and constants of the probe slice run-length decoder
`timescale 1ns / 1ps
`default_nettype none

package psrld_pkg;

  localparam int unsigned CODE_W     = 16;
  localparam int unsigned SLICE_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned RUN_W      = 7;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned RAW_CNT_W  = 4;
  localparam int unsigned RAW_WORDS  = 8;

  localparam logic [CODE_W-1:0]    FULL_SHADE_WORD = 16'h4000;
  localparam logic [CODE_W-1:0]    RAW_MARKER_WORD = 16'h7FFF;
  localparam int unsigned          START_BIT       = 14;
  localparam logic [COUNT_W-1:0]   COUNT_MAX       = 8'hFF;
  localparam logic [COUNT_W:0]     SLICE_PIXELS    = 9'd128;
  localparam logic [RAW_CNT_W-1:0] RAW_WORDS_INIT  = 4'd8;

  // one finished slice waiting to be sent as two halves
  typedef struct packed {
    logic [SLICE_W-1:0] pixels;
    logic               dropped;
    logic               last;
  } slice_job_t;

  // up to two slices leave the front per accepted word, first then second
  typedef struct packed {
    logic       first_valid;
    slice_job_t first;
    logic       second_valid;
    slice_job_t second;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/psrld_in_if.sv =====
// input channel: compressed words
`timescale 1ns / 1ps
`default_nettype none

interface psrld_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic        end_of_particle;

  modport source (output valid, output code_word, output end_of_particle, input ready);
  modport sink (input valid, input code_word, input end_of_particle, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psrld_out_if.sv =====
// output channel: slice halves
`timescale 1ns / 1ps
`default_nettype none

interface psrld_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] slice_half;
  logic        upper_half;
  logic        run_dropped;
  logic        last;

  modport source (output valid, output slice_half, output upper_half, output run_dropped,
                  output last, input ready);
  modport sink (input valid, input slice_half, input upper_half, input run_dropped,
                input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psrld_front.sv =====
// front end: classifies each word, keeps the open slice and hands finished slices on
`timescale 1ns / 1ps
`default_nettype none

module psrld_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  psrld_in_if.sink          code_i,
  input  wire               space_i,
  output psrld_pkg::push_t  push_o
);

  typedef enum logic [1:0] {
    KIND_RAW_DATA,
    KIND_FULL,
    KIND_RAW_MARK,
    KIND_RUN
  } word_kind_e;

  localparam logic [psrld_pkg::SLICE_W-1:0] ONES = '1;

  logic [psrld_pkg::SLICE_W-1:0]   pix_q, pix_d;
  logic [psrld_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [psrld_pkg::RAW_CNT_W-1:0] raw_q, raw_d;
  logic                            ovf_q, ovf_d;

  logic                            accept;
  logic [psrld_pkg::CODE_W-1:0]    word;
  logic                            eop;
  word_kind_e                      kind;
  logic                            open_slice;

  logic [psrld_pkg::RAW_CNT_W-1:0] raw_dec;
  logic [2:0]                      raw_idx;
  logic [psrld_pkg::SLICE_W-1:0]   raw_pix;

  logic [psrld_pkg::RUN_W-1:0]     clr_run, shd_run;
  logic                            start_word;
  logic [psrld_pkg::SLICE_W-1:0]   base_pix, shade_mask, run_pix;
  logic [psrld_pkg::COUNT_W-1:0]   base_cnt, clr_cnt, run_cnt;
  logic                            base_ovf, run_ovf, shade_over, shade_ok;
  logic [psrld_pkg::COUNT_W:0]     clr_sum, end_sum;

  assign code_i.ready = space_i;
  assign accept       = code_i.valid && space_i;
  assign word         = code_i.code_word;
  assign eop          = code_i.end_of_particle;
  assign open_slice   = (cnt_q != '0);

  always_comb begin
    priority if (raw_q != '0) begin
      kind = KIND_RAW_DATA;
    end else if (word == psrld_pkg::FULL_SHADE_WORD) begin
      kind = KIND_FULL;
    end else if (word == psrld_pkg::RAW_MARKER_WORD) begin
      kind = KIND_RAW_MARK;
    end else begin
      kind = KIND_RUN;
    end
  end

  // raw word j lands at bits 16j..16j+15
  always_comb begin
    raw_dec = raw_q - 1'b1;
    raw_idx = 3'(psrld_pkg::RAW_WORDS_INIT - raw_q);
    raw_pix = pix_q;
    raw_pix[{raw_idx, 4'b0000} +: psrld_pkg::CODE_W] = word;
  end

  // run word: clear run then shaded run at the running count
  always_comb begin
    clr_run    = word[psrld_pkg::RUN_W-1:0];
    shd_run    = word[2*psrld_pkg::RUN_W-1:psrld_pkg::RUN_W];
    start_word = word[psrld_pkg::START_BIT];
    base_pix   = start_word ? ONES : pix_q;
    base_cnt   = start_word ? '0 : cnt_q;
    base_ovf   = start_word ? 1'b0 : ovf_q;
    clr_sum    = {1'b0, base_cnt} + {2'b00, clr_run};
    clr_cnt    = clr_sum[psrld_pkg::COUNT_W] ? psrld_pkg::COUNT_MAX
                                             : clr_sum[psrld_pkg::COUNT_W-1:0];
    end_sum    = {1'b0, clr_cnt} + {2'b00, shd_run};
    shade_over = (shd_run != '0) && (end_sum > psrld_pkg::SLICE_PIXELS);
    shade_ok   = (shd_run != '0) && !shade_over;
    // end_sum of 128 shifts everything out, so the mask runs to the top pixel
    shade_mask = (ONES << clr_cnt) & ~(ONES << end_sum[psrld_pkg::COUNT_W-1:0]);
    run_pix    = shade_ok ? (base_pix & ~shade_mask) : base_pix;
    run_cnt    = shade_ok ? end_sum[psrld_pkg::COUNT_W-1:0] : clr_cnt;
    run_ovf    = base_ovf || shade_over;
  end

  always_comb begin
    pix_d = pix_q;
    cnt_d = cnt_q;
    raw_d = raw_q;
    ovf_d = ovf_q;
    push_o.first_valid         = 1'b0;
    push_o.first.pixels        = pix_q;
    push_o.first.dropped       = ovf_q;
    push_o.second_valid        = 1'b0;
    push_o.second.pixels       = ONES;
    push_o.second.dropped      = 1'b0;
    push_o.second.last         = 1'b1;
    if (accept) begin
      unique case (kind)
        KIND_RAW_DATA: begin
          push_o.first.pixels  = raw_pix;
          push_o.first.dropped = 1'b0;
          if ((raw_dec == '0) || eop) begin
            push_o.first_valid = 1'b1;
            pix_d = ONES;
            raw_d = '0;
          end else begin
            pix_d = raw_pix;
            raw_d = raw_dec;
          end
        end
        KIND_FULL: begin
          push_o.first_valid   = open_slice;
          push_o.second_valid  = 1'b1;
          push_o.second.pixels = '0;
          pix_d = ONES;
          cnt_d = '0;
          ovf_d = 1'b0;
        end
        KIND_RAW_MARK: begin
          push_o.first_valid  = open_slice;
          // a marker that ends the particle yields an all-clear slice
          push_o.second_valid = eop;
          raw_d = eop ? '0 : psrld_pkg::RAW_WORDS_INIT;
          pix_d = ONES;
          cnt_d = '0;
          ovf_d = 1'b0;
        end
        KIND_RUN: begin
          push_o.first_valid    = start_word && open_slice;
          push_o.second_valid   = eop && (run_cnt != '0);
          push_o.second.pixels  = run_pix;
          push_o.second.dropped = run_ovf;
          if (push_o.second_valid) begin
            pix_d = ONES;
            cnt_d = '0;
            ovf_d = 1'b0;
          end else begin
            pix_d = run_pix;
            cnt_d = run_cnt;
            ovf_d = run_ovf;
          end
        end
        default: begin
          pix_d = pix_q;
        end
      endcase
    end
    push_o.first.last = !push_o.second_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= ONES;
      cnt_q <= '0;
      raw_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      cnt_q <= cnt_d;
      raw_q <= raw_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psrld_queue.sv =====
// slice queue between front and back, takes up to two slices a cycle
`timescale 1ns / 1ps
`default_nettype none

module psrld_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  psrld_pkg::push_t       push_i,
  output logic                   space_o,
  output logic                   head_valid_o,
  output psrld_pkg::slice_job_t  head_o,
  input  wire                    pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  psrld_pkg::slice_job_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, second_ptr, after_first;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign after_first  = ptr_inc(wr_ptr_q);
  assign second_ptr   = push_i.first_valid ? after_first : wr_ptr_q;
  assign space_o      = (cnt_q <= CntW'(Depth - 2));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.first_valid) begin
      wr_ptr_d = after_first;
    end
    if (push_i.second_valid) begin
      wr_ptr_d = ptr_inc(second_ptr);
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.first_valid) + CntW'(push_i.second_valid)
               - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_valid) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.second_valid) begin
      mem_q[second_ptr] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psrld_back.sv =====
// back end: sends each queued slice as lower then upper half through an output register
`timescale 1ns / 1ps
`default_nettype none

module psrld_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    head_valid_i,
  input  psrld_pkg::slice_job_t  head_i,
  output logic                   pop_o,
  psrld_out_if.source            slice_o
);

  logic                          valid_q, valid_d;
  logic                          upper_q, upper_d;
  logic [psrld_pkg::HALF_W-1:0]  half_q, half_d;
  logic                          dropped_q, dropped_d;
  logic                          last_q, last_d;
  logic                          sel_q, sel_d;
  logic                          load;

  assign load = !valid_q || slice_o.ready;

  always_comb begin
    valid_d   = valid_q;
    upper_d   = upper_q;
    half_d    = half_q;
    dropped_d = dropped_q;
    last_d    = last_q;
    sel_d     = sel_q;
    pop_o     = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        half_d    = sel_q ? head_i.pixels[2*psrld_pkg::HALF_W-1:psrld_pkg::HALF_W]
                          : head_i.pixels[psrld_pkg::HALF_W-1:0];
        upper_d   = sel_q;
        dropped_d = head_i.dropped;
        last_d    = sel_q && head_i.last;
        sel_d     = !sel_q;
        // slice leaves the queue with its upper half
        pop_o     = sel_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q   <= upper_d;
    half_q    <= half_d;
    dropped_q <= dropped_d;
    last_q    <= last_d;
  end

  assign slice_o.valid       = valid_q;
  assign slice_o.slice_half  = half_q;
  assign slice_o.upper_half  = upper_q;
  assign slice_o.run_dropped = dropped_q;
  assign slice_o.last        = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/probe_slice_run_length_decoder.sv =====
// Probe slice run-length decoder, top level
//
// code_i takes one 16-bit word per transaction with an end-of-particle flag;
// slice_o gives each finished 128-pixel slice as two 64-bit halves, lower
// first, with last set on the final half that a word causes.
// Input: one word per cycle while at least two slice entries are free in the
// queue; a word yields zero, one or two slices, so up to four halves.
// Output: one half per cycle while slice_o is ready; each slice goes out as two
// halves, which sets the sustained rate when slices come faster than one per two words.
// Path: a slice finished by an accepted word is written to the queue, then loaded into
// the output register as its lower half once that register is free, then its upper half.
// The slice state is updated once per accepted word with a 128-bit run mask.
// Reset: slice store all clear, counts zero, queue and output register empty.
// When slice_o stalls, the held half stays stable, the queue fills, and
// code_i drops ready once fewer than two queue entries are free.
`timescale 1ns / 1ps
`default_nettype none

module probe_slice_run_length_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  psrld_in_if.sink     code_i,
  psrld_out_if.source  slice_o
);

  psrld_pkg::push_t      push;
  psrld_pkg::slice_job_t head;
  logic                  space;
  logic                  head_valid;
  logic                  pop;

  psrld_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_i),
    .space_i (space),
    .push_o  (push)
  );

  psrld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  psrld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .slice_o      (slice_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/psrld_checker.sv =====
// port checker for the slice decoder and its bind
`timescale 1ns / 1ps
`default_nettype none

module psrld_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [63:0] half_i,
  input wire        upper_i,
  input wire        dropped_i,
  input wire        last_i
);

  // stalled half holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(half_i) && $stable(upper_i)
      && $stable(last_i))
    else $error("slice half changed while stalled");

  // upper half follows the lower half at once, same overflow flag
  a_upper_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !upper_i |=> out_valid_i && upper_i
      && (dropped_i == $past(dropped_i)))
    else $error("upper half did not follow lower half");

  // a transaction never ends on a lower half
  a_last_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> upper_i)
    else $error("last set on a lower half");

endmodule

bind probe_slice_run_length_decoder psrld_checker u_psrld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (slice_o.valid),
  .out_ready_i (slice_o.ready),
  .half_i      (slice_o.slice_half),
  .upper_i     (slice_o.upper_half),
  .dropped_i   (slice_o.run_dropped),
  .last_i      (slice_o.last)
);

`default_nettype wire

// ===== test/tb_probe_slice_run_length_decoder.sv =====
// testbench for the probe slice run-length decoder: random and directed word streams, scoreboard
`timescale 1ns / 1ps

module tb_probe_slice_run_length_decoder;

  typedef struct {
    logic [psrld_pkg::HALF_W-1:0] pixels;
    logic                         upper;
    logic                         dropped;
    logic                         last;
  } half_t;

  // tracks the slice under construction and the halves the block owes us
  class slice_rebuilder;
    logic [psrld_pkg::SLICE_W-1:0] image_slice;
    int unsigned                   pixel_count;
    int unsigned                   raw_left;
    logic                          overflow_seen;
    half_t                         expected_halves[$];
    int unsigned                   error_count;

    function new();
      image_slice   = '1;
      pixel_count   = 0;
      raw_left      = 0;
      overflow_seen = 1'b0;
      error_count   = 0;
    endfunction

    function void emit_slice(logic dropped);
      half_t h;
      for (int i = 0; i < 2; i++) begin
        h.pixels  = image_slice[i*psrld_pkg::HALF_W +: psrld_pkg::HALF_W];
        h.upper   = (i == 1);
        h.dropped = dropped;
        h.last    = 1'b0;
        expected_halves.push_back(h);
      end
      image_slice   = '1;
      pixel_count   = 0;
      overflow_seen = 1'b0;
    endfunction

    function void close_open();
      if (pixel_count > 0) emit_slice(overflow_seen);
    endfunction

    function void note_word(logic [psrld_pkg::CODE_W-1:0] word, logic eop);
      int unsigned                   base;
      int unsigned                   clr;
      int unsigned                   shd;
      int unsigned                   j;
      logic [psrld_pkg::SLICE_W-1:0] run_mask;
      base = expected_halves.size();
      if (raw_left > 0) begin
        j = psrld_pkg::RAW_WORDS - raw_left;
        image_slice[16*j +: 16] = word;
        raw_left--;
        if (raw_left == 0) emit_slice(1'b0);
      end else if (word == psrld_pkg::FULL_SHADE_WORD) begin
        close_open();
        image_slice = '0;
        emit_slice(1'b0);
      end else if (word == psrld_pkg::RAW_MARKER_WORD) begin
        close_open();
        raw_left = psrld_pkg::RAW_WORDS;
      end else begin
        clr = word[6:0];
        shd = word[13:7];
        if (word[psrld_pkg::START_BIT]) close_open();
        pixel_count += clr;
        if (pixel_count > psrld_pkg::COUNT_MAX) pixel_count = psrld_pkg::COUNT_MAX;
        if (shd > 0) begin
          if (pixel_count + shd > psrld_pkg::SLICE_PIXELS) begin
            overflow_seen = 1'b1;
          end else begin
            // bits [count, count+shd) go shaded; a shift by 128 gives all ones after -1
            run_mask = ((128'd1 << (pixel_count + shd)) - 1) ^ ((128'd1 << pixel_count) - 1);
            image_slice &= ~run_mask;
            pixel_count += shd;
          end
        end
      end
      if (eop) begin
        if (raw_left > 0) begin
          raw_left = 0;
          emit_slice(1'b0);
        end else begin
          close_open();
        end
      end
      if (expected_halves.size() > base)
        expected_halves[expected_halves.size()-1].last = 1'b1;
    endfunction

    function void check_half(half_t got);
      half_t want;
      if (expected_halves.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected half: pixels=%h upper=%0b dropped=%0b last=%0b",
                   got.pixels, got.upper, got.dropped, got.last);
        return;
      end
      want = expected_halves.pop_front();
      if (got.pixels !== want.pixels || got.upper !== want.upper ||
          got.dropped !== want.dropped || got.last !== want.last) begin
        error_count++;
        if (error_count <= 10)
          $display({"half mismatch: exp pixels=%h upper=%0b dropped=%0b last=%0b, ",
                    "got pixels=%h upper=%0b dropped=%0b last=%0b"},
                   want.pixels, want.upper, want.dropped, want.last,
                   got.pixels, got.upper, got.dropped, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psrld_in_if  code_if();
  psrld_out_if slice_if();

  probe_slice_run_length_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_if),
    .slice_o (slice_if)
  );

  slice_rebuilder decoder_shadow = new();
  bit             steady = 1'b0;
  bit             hold_req = 1'b0;
  int unsigned    words_accepted = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: random back-pressure plus one long hold-off on request
  initial begin
    slice_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        slice_if.ready <= 1'b0;
        for (int c = 0; c < 80; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        slice_if.ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk_i) begin
    half_t got;
    if (rst_ni && slice_if.valid && slice_if.ready) begin
      got.pixels  = slice_if.slice_half;
      got.upper   = slice_if.upper_half;
      got.dropped = slice_if.run_dropped;
      got.last    = slice_if.last;
      decoder_shadow.check_half(got);
    end
  end

  // called and returns at a falling edge
  task automatic send_word(input logic [psrld_pkg::CODE_W-1:0] word, input logic eop);
    while (!steady && $urandom_range(99) < 38) begin
      code_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    code_if.valid           <= 1'b1;
    code_if.code_word       <= word;
    code_if.end_of_particle <= eop;
    @(posedge clk_i);
    while (!code_if.ready) @(posedge clk_i);
    decoder_shadow.note_word(word, eop);
    words_accepted++;
    @(negedge clk_i);
  endtask

  function automatic logic [psrld_pkg::RUN_W-1:0] run_len();
    if ($urandom_range(9) == 0) return psrld_pkg::RUN_W'($urandom);
    return psrld_pkg::RUN_W'($urandom_range(0, 30));
  endfunction

  // a well-formed particle: a few slices of mixed kinds, eop on its final word
  task automatic send_particle();
    logic [psrld_pkg::CODE_W-1:0] words[$];
    int unsigned                  slice_n;
    int unsigned                  kind;
    int unsigned                  raw_n;
    slice_n = $urandom_range(1, 4);
    for (int s = 0; s < slice_n; s++) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        words.push_back(psrld_pkg::FULL_SHADE_WORD);
      end else if (kind < 25) begin
        words.push_back(psrld_pkg::RAW_MARKER_WORD);
        // the particle may end in the middle of a raw slice
        raw_n = (s == slice_n - 1 && $urandom_range(4) == 0) ? $urandom_range(0, 7)
                                                               : psrld_pkg::RAW_WORDS;
        repeat (raw_n) words.push_back(psrld_pkg::CODE_W'($urandom));
      end else begin
        words.push_back({1'($urandom), 1'b1, run_len(), run_len()});
        repeat ($urandom_range(0, 4))
          words.push_back({1'($urandom), 1'b0, run_len(), run_len()});
      end
    end
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  initial begin
    bit pressure_done;
    pressure_done           = 1'b0;
    code_if.valid           = 1'b0;
    code_if.code_word       = '0;
    code_if.end_of_particle = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(psrld_pkg::FULL_SHADE_WORD, 1'b0);
    send_word(16'h4A0A, 1'b0);          // start with nothing open
    send_word(16'h0F05, 1'b0);
    send_word(16'h3F80, 1'b0);          // shaded run too long, dropped
    send_word(16'h4181, 1'b0);          // start closes the flagged slice
    send_word(psrld_pkg::FULL_SHADE_WORD, 1'b0);   // closes open slice, then full shade
    send_word(16'h4001, 1'b0);
    send_word(psrld_pkg::RAW_MARKER_WORD, 1'b0);   // closes open slice
    send_word(psrld_pkg::RAW_MARKER_WORD, 1'b0);   // raw data, whatever the value
    send_word(psrld_pkg::FULL_SHADE_WORD, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h8001, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'hC3A5, 1'b0);
    send_word(16'h0F0F, 1'b0);
    send_word(16'h407F, 1'b0);          // clear runs up to saturation
    send_word(16'h007F, 1'b0);
    send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(psrld_pkg::RAW_MARKER_WORD, 1'b0);   // raw slice cut short by eop
    send_word(16'h1234, 1'b0);
    send_word(16'hABCD, 1'b1);
    send_word(psrld_pkg::RAW_MARKER_WORD, 1'b1);   // marker with eop gives all clear
    send_word(16'hFF81, 1'b1);          // shade exactly to pixel 128
    send_word(16'h0000, 1'b1);          // eop with nothing open

    while (words_accepted < 315) begin
      if (!pressure_done && words_accepted >= 90) begin
        // output stalls while full-shade slices keep coming in
        pressure_done = 1'b1;
        steady        = 1'b1;
        hold_req      = 1'b1;
        repeat (16) send_word(psrld_pkg::FULL_SHADE_WORD, 1'($urandom));
      end
      steady = (words_accepted >= 170 && words_accepted < 240);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_word(psrld_pkg::CODE_W'($urandom), $urandom_range(4) == 0);
      end else begin
        send_particle();
      end
    end
    code_if.valid <= 1'b0;
    steady = 1'b0;

    while (decoder_shadow.expected_halves.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (decoder_shadow.error_count == 0 && decoder_shadow.expected_halves.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
